FILE: sv/cpg_pkg.sv
// ----------------------------------------------------------------------------
// cpg_pkg
// Shared types and constants of the circle point generator.
// ----------------------------------------------------------------------------
package cpg_pkg;

   localparam int CENTRE_W = 11;
   localparam int COORD_W  = 12;
   localparam int COLOR_W  = 32;

   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   typedef enum logic {
      JOB_AXIS    = 1'b0,
      JOB_OCTANT  = 1'b1
   } job_kind_type;

   // one unit of back-end work: four axis points or eight octant points
   typedef struct packed {
      job_kind_type              kind;
      logic [CENTRE_W-1:0]       centre_col;
      logic [CENTRE_W-1:0]       centre_row;
      logic [COORD_W-1:0]        along;
      logic [COORD_W-1:0]        across;
      logic [COLOR_W-1:0]        color;
      logic                      done;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_push_type;

endpackage

FILE: sv/cpg_front.sv
// ----------------------------------------------------------------------------
// cpg_front
// Accepts commands, steps the decision variable and queues point jobs.
// ----------------------------------------------------------------------------
module cpg_front #(
   parameter int RADIUS_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [cpg_pkg::CENTRE_W-1:0]  req_center_x,
   input  logic [cpg_pkg::CENTRE_W-1:0]  req_center_y,
   input  logic [9:0]                    req_radius,
   input  logic [cpg_pkg::COLOR_W-1:0]   req_color,
   input  logic                          csr_valid,
   input  logic [cpg_pkg::COLOR_W-1:0]   csr_wdata,
   input  logic                          queue_full,
   output cpg_pkg::job_push_type         push
);

   localparam int OW = RADIUS_BITS + 1;
   localparam int DW = RADIUS_BITS + 4;

   logic [cpg_pkg::COLOR_W-1:0]  transparent_ff, transparent_in;
   logic [cpg_pkg::CENTRE_W-1:0] centre_col_ff, centre_col_in;
   logic [cpg_pkg::CENTRE_W-1:0] centre_row_ff, centre_row_in;
   logic [cpg_pkg::COLOR_W-1:0]  color_ff, color_in;
   logic [OW-1:0]                along_ff, along_in;
   logic [OW-1:0]                across_ff, across_in;
   logic signed [DW-1:0]         decision_ff, decision_in;
   logic                         active_ff, active_in;

   logic [RADIUS_BITS+9:0]       radius_ext;
   logic [RADIUS_BITS-1:0]       radius;
   logic signed [DW-1:0]         along_s, across_s, radius_s;
   logic [OW:0]                  next_along;
   logic [OW:0]                  next_across;
   logic                         passes;
   logic                         accept;

   assign req_ready  = !queue_full;
   assign accept     = req_valid && req_ready;
   assign radius_ext = {{RADIUS_BITS{1'b0}}, req_radius};
   assign radius     = radius_ext[RADIUS_BITS-1:0];
   assign along_s    = $signed(DW'(along_ff));
   assign across_s   = $signed(DW'(across_ff));
   assign radius_s   = $signed(DW'(radius));

   always_comb begin
      transparent_in = csr_valid ? csr_wdata : transparent_ff;
      centre_col_in  = centre_col_ff;
      centre_row_in  = centre_row_ff;
      color_in       = color_ff;
      along_in       = along_ff;
      across_in      = across_ff;
      decision_in    = decision_ff;
      active_in      = active_ff;
      push           = '0;

      if (accept && req_command == cpg_pkg::CMD_START) begin
         centre_col_in = req_center_x;
         centre_row_in = req_center_y;
         color_in      = req_color;
         along_in      = '0;
         across_in     = OW'(radius);
         decision_in   = DW'(3) - (radius_s <<< 1);
      end else if (accept && active_ff) begin
         if (decision_ff >= 0) begin
            decision_in = decision_ff + ((along_s - across_s) <<< 2) + DW'(10);
            across_in   = across_ff - OW'(1);
         end else begin
            decision_in = decision_ff + (along_s <<< 2) + DW'(6);
         end
         along_in = along_ff + OW'(1);
      end

      next_along  = {1'b0, along_in} + (OW+1)'(1);
      next_across = (decision_in >= 0) ? ({1'b0, across_in} - (OW+1)'(1))
                                       : {1'b0, across_in};
      passes      = next_along > next_across;

      push.job.kind       = (req_command == cpg_pkg::CMD_START) ? cpg_pkg::JOB_AXIS
                                                                : cpg_pkg::JOB_OCTANT;
      push.job.centre_col = centre_col_in;
      push.job.centre_row = centre_row_in;
      push.job.along      = cpg_pkg::COORD_W'(along_in);
      push.job.across     = cpg_pkg::COORD_W'(across_in);
      push.job.color      = color_in;
      push.job.done       = passes;

      if (accept && req_command == cpg_pkg::CMD_START) begin
         if (radius == '0 || req_color == transparent_ff) begin
            active_in = 1'b0;
         end else begin
            push.valid = 1'b1;
            active_in  = !passes;
         end
      end else if (accept && active_ff) begin
         push.valid = 1'b1;
         if (passes) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         transparent_ff <= '0;
         centre_col_ff  <= '0;
         centre_row_ff  <= '0;
         color_ff       <= '0;
         along_ff       <= '0;
         across_ff      <= '0;
         decision_ff    <= '0;
         active_ff      <= 1'b0;
      end else begin
         transparent_ff <= transparent_in;
         centre_col_ff  <= centre_col_in;
         centre_row_ff  <= centre_row_in;
         color_ff       <= color_in;
         along_ff       <= along_in;
         across_ff      <= across_in;
         decision_ff    <= decision_in;
         active_ff      <= active_in;
      end
   end

endmodule

FILE: sv/cpg_queue.sv
// ----------------------------------------------------------------------------
// cpg_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module cpg_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  cpg_pkg::job_push_type push,
   output logic                  full,
   output logic                  pop_valid,
   output cpg_pkg::job_type      pop_job,
   input  logic                  pop
);

   cpg_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = count_ff == 2'd2;
   assign pop_valid = count_ff != 2'd0;
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

FILE: sv/cpg_back.sv
// ----------------------------------------------------------------------------
// cpg_back
// Expands each job into its symmetric points, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module cpg_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  cpg_pkg::job_type              job,
   output logic                          job_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cpg_pkg::COORD_W-1:0]   rsp_point_x,
   output logic [cpg_pkg::COORD_W-1:0]   rsp_point_y,
   output logic [cpg_pkg::COLOR_W-1:0]   rsp_point_color,
   output logic                          rsp_last_of_run,
   output logic                          rsp_circle_done
);

   localparam int CW = cpg_pkg::COORD_W;

   logic [2:0]    step_ff, step_in;
   logic          valid_ff, valid_in;
   logic [CW-1:0] x_ff, x_in;
   logic [CW-1:0] y_ff, y_in;
   logic [cpg_pkg::COLOR_W-1:0] color_ff;
   logic          last_ff, last_in;
   logic          done_ff, done_in;

   logic          load;
   logic [CW-1:0] cx, cy, xm, ym;
   logic          xneg, yneg;

   assign load = job_valid && (!valid_ff || rsp_ready);
   assign cx   = {job.centre_col[cpg_pkg::CENTRE_W-1], job.centre_col};
   assign cy   = {job.centre_row[cpg_pkg::CENTRE_W-1], job.centre_row};

   always_comb begin
      xm   = '0;
      ym   = '0;
      xneg = 1'b0;
      yneg = 1'b0;
      if (job.kind == cpg_pkg::JOB_AXIS) begin
         case (step_ff)
            3'd0: begin ym = job.across; end
            3'd1: begin ym = job.across; yneg = 1'b1; end
            3'd2: begin xm = job.across; end
            3'd3: begin xm = job.across; xneg = 1'b1; end
            default: begin xm = '0; ym = '0; end
         endcase
      end else begin
         case (step_ff)
            3'd0: begin xm = job.across; ym = job.along; end
            3'd1: begin xm = job.along; ym = job.across; end
            3'd2: begin xm = job.along; ym = job.across; xneg = 1'b1; end
            3'd3: begin xm = job.across; ym = job.along; xneg = 1'b1; end
            3'd4: begin xm = job.across; ym = job.along; xneg = 1'b1; yneg = 1'b1; end
            3'd5: begin xm = job.along; ym = job.across; xneg = 1'b1; yneg = 1'b1; end
            3'd6: begin xm = job.along; ym = job.across; yneg = 1'b1; end
            default: begin xm = job.across; ym = job.along; yneg = 1'b1; end
         endcase
      end

      x_in    = xneg ? cx - xm : cx + xm;
      y_in    = yneg ? cy - ym : cy + ym;
      last_in = (job.kind == cpg_pkg::JOB_AXIS) ? (step_ff == 3'd3) : (step_ff == 3'd7);
      done_in = last_in && job.done;

      job_pop  = load && last_in;
      step_in  = step_ff;
      valid_in = valid_ff && !rsp_ready;
      if (load) begin
         valid_in = 1'b1;
         step_in  = last_in ? 3'd0 : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // hold the payload while the transfer stalls
   always_ff @(posedge clock) begin
      if (load) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         color_ff <= job.color;
         last_ff  <= last_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_point_x     = x_ff;
   assign rsp_point_y     = y_ff;
   assign rsp_point_color = color_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_circle_done = done_ff;

endmodule

FILE: sv/circle_point_generator.sv
// ----------------------------------------------------------------------------
// circle_point_generator
// Midpoint circle outline generator: start and advance commands in,
// coordinates and colour out.
// ----------------------------------------------------------------------------
// A start command gives the four axis points and each advance command gives
// eight points. The sustained rate is set by the back end's single
// point-per-cycle output register, which can be stalled by rsp_ready. A
// two-entry job queue lets the front end accept the next command while the
// back end drains. Starts that draw nothing and advances with no circle in
// progress are taken at the input but give no transfer.
// ----------------------------------------------------------------------------
module circle_point_generator #(
   parameter int RADIUS_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [cpg_pkg::CENTRE_W-1:0]  req_center_x,
   input  logic [cpg_pkg::CENTRE_W-1:0]  req_center_y,
   input  logic [9:0]                    req_radius,
   input  logic [cpg_pkg::COLOR_W-1:0]   req_color,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cpg_pkg::COORD_W-1:0]   rsp_point_x,
   output logic [cpg_pkg::COORD_W-1:0]   rsp_point_y,
   output logic [cpg_pkg::COLOR_W-1:0]   rsp_point_color,
   output logic                          rsp_last_of_run,
   output logic                          rsp_circle_done,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cpg_pkg::COLOR_W-1:0]   csr_wdata
);

   cpg_pkg::job_push_type push;
   cpg_pkg::job_type      head_job;
   logic                  queue_full;
   logic                  head_valid;
   logic                  head_pop;

   assign csr_ready = 1'b1;

   cpg_front #(
      .RADIUS_BITS (RADIUS_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .req_color    (req_color),
      .csr_valid    (csr_valid),
      .csr_wdata    (csr_wdata),
      .queue_full   (queue_full),
      .push         (push)
   );

   cpg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .pop_valid (head_valid),
      .pop_job   (head_job),
      .pop       (head_pop)
   );

   cpg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (head_valid),
      .job             (head_job),
      .job_pop         (head_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_color (rsp_point_color),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_circle_done (rsp_circle_done)
   );

endmodule

FILE: tb/sv/circle_point_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_point_generator_tb
// Self-checking bench for the midpoint circle outline generator.
// ----------------------------------------------------------------------------
// Start and advance commands are queued by the stimulus process and sent by a
// clocked driver. A clocked monitor keeps its own midpoint-circle tracker in
// step with every accepted command and checks each point transfer, field by
// field, against the oldest predicted point. A short directed pass covers the
// empty and transparent starts, radius one, the extreme centres and radii,
// advances with no circle and restarts over a circle in progress. Random
// passes follow under several transparent keys, with random gaps on both
// channels, and a last pass runs with no idling.
// ----------------------------------------------------------------------------
module circle_point_generator_tb;

   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 32;
   localparam int QUIET_LIMIT   = 2000;

   typedef struct packed {
      logic                         command;
      logic [cpg_pkg::CENTRE_W-1:0] center_x;
      logic [cpg_pkg::CENTRE_W-1:0] center_y;
      logic [9:0]                   radius;
      logic [cpg_pkg::COLOR_W-1:0]  color;
   } circle_cmd_type;

   typedef struct packed {
      logic [cpg_pkg::COORD_W-1:0] x;
      logic [cpg_pkg::COORD_W-1:0] y;
      logic [cpg_pkg::COLOR_W-1:0] color;
      logic                        last_of_run;
      logic                        circle_done;
   } outline_point_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_command = cpg_pkg::CMD_START;
   logic [cpg_pkg::CENTRE_W-1:0] req_center_x = '0;
   logic [cpg_pkg::CENTRE_W-1:0] req_center_y = '0;
   logic [9:0]                   req_radius = '0;
   logic [cpg_pkg::COLOR_W-1:0]  req_color = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [cpg_pkg::COORD_W-1:0]  rsp_point_x;
   logic [cpg_pkg::COORD_W-1:0]  rsp_point_y;
   logic [cpg_pkg::COLOR_W-1:0]  rsp_point_color;
   logic                         rsp_last_of_run;
   logic                         rsp_circle_done;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [cpg_pkg::COLOR_W-1:0]  csr_wdata = '0;

   circle_cmd_type    pending_cmds[$];
   outline_point_type expected_points[$];
   circle_cmd_type    next_cmd;
   circle_cmd_type    taken_cmd;
   outline_point_type got_point;

   // tracker state
   logic [cpg_pkg::COLOR_W-1:0] key_color = '0;
   int                          centre_col = 0;
   int                          centre_row = 0;
   logic [cpg_pkg::COLOR_W-1:0] held_color = '0;
   int                          along = 0;
   int                          across = 0;
   int                          decision = 0;
   bit                          circle_live = 1'b0;

   bit idle_on = 1'b1;
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int gap_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   int error_count = 0;
   int queued_count = 0;
   int accepted_count = 0;
   int starts_taken = 0;
   int advances_taken = 0;
   int points_checked = 0;
   int circles_finished = 0;
   int keys_written = 0;

   circle_point_generator DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_radius      (req_radius),
      .req_color       (req_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_color (rsp_point_color),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_circle_done (rsp_circle_done),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- tracker
   function automatic void emit_point(int px, int py);
      outline_point_type p;
      p.x           = cpg_pkg::COORD_W'(px);
      p.y           = cpg_pkg::COORD_W'(py);
      p.color       = held_color;
      p.last_of_run = 1'b0;
      p.circle_done = 1'b0;
      expected_points.push_back(p);
   endfunction

   function automatic bit passes_diagonal();
      int next_across;
      next_across = (decision >= 0) ? across - 1 : across;
      return (along + 1) > next_across;
   endfunction

   function automatic void close_run(bit done);
      expected_points[expected_points.size() - 1].last_of_run = 1'b1;
      expected_points[expected_points.size() - 1].circle_done = done;
      if (done) circles_finished++;
   endfunction

   function automatic void trace_outline(circle_cmd_type cmd);
      int r;
      bit done;
      if (cmd.command == cpg_pkg::CMD_START) begin
         r           = int'(cmd.radius);
         centre_col  = int'($signed(cmd.center_x));
         centre_row  = int'($signed(cmd.center_y));
         held_color  = cmd.color;
         circle_live = 1'b0;
         if (r == 0 || cmd.color == key_color) return;
         along    = 0;
         across   = r;
         decision = 3 - 2 * r;
         emit_point(centre_col, centre_row + r);
         emit_point(centre_col, centre_row - r);
         emit_point(centre_col + r, centre_row);
         emit_point(centre_col - r, centre_row);
         done = passes_diagonal();
         close_run(done);
         circle_live = !done;
         return;
      end
      if (!circle_live) return;
      if (decision >= 0) begin
         decision += 4 * (along - across) + 10;
         across   -= 1;
      end else begin
         decision += 4 * along + 6;
      end
      along += 1;
      emit_point(centre_col + across, centre_row + along);
      emit_point(centre_col + along, centre_row + across);
      emit_point(centre_col - along, centre_row + across);
      emit_point(centre_col - across, centre_row + along);
      emit_point(centre_col - across, centre_row - along);
      emit_point(centre_col - along, centre_row - across);
      emit_point(centre_col + along, centre_row - across);
      emit_point(centre_col + across, centre_row - along);
      done = passes_diagonal();
      close_run(done);
      if (done) circle_live = 1'b0;
   endfunction

   function automatic void check_field(string name, logic [cpg_pkg::COLOR_W-1:0] want,
                                       logic [cpg_pkg::COLOR_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 99) < req_gap_pct) begin
            gap_left  <= $urandom_range(0, 16);
            req_valid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            next_cmd     = pending_cmds.pop_front();
            req_valid    <= 1'b1;
            req_command  <= next_cmd.command;
            req_center_x <= next_cmd.center_x;
            req_center_y <= next_cmd.center_y;
            req_radius   <= next_cmd.radius;
            req_color    <= next_cmd.color;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $display("%0t: point expected none got x=%0d y=%0d color=0x%0h", $time,
                        $signed(rsp_point_x), $signed(rsp_point_y), rsp_point_color);
               error_count++;
            end else begin
               got_point = expected_points.pop_front();
               check_field("point_x", cpg_pkg::COLOR_W'(got_point.x),
                           cpg_pkg::COLOR_W'(rsp_point_x));
               check_field("point_y", cpg_pkg::COLOR_W'(got_point.y),
                           cpg_pkg::COLOR_W'(rsp_point_y));
               check_field("point_color", got_point.color, rsp_point_color);
               check_field("last_of_run", cpg_pkg::COLOR_W'(got_point.last_of_run),
                           cpg_pkg::COLOR_W'(rsp_last_of_run));
               check_field("circle_done", cpg_pkg::COLOR_W'(got_point.circle_done),
                           cpg_pkg::COLOR_W'(rsp_circle_done));
               points_checked++;
            end
         end
         if (req_valid && req_ready) begin
            taken_cmd = '{req_command, req_center_x, req_center_y, req_radius, req_color};
            if (req_command == cpg_pkg::CMD_START) starts_taken++;
            else advances_taken++;
            trace_outline(taken_cmd);
            accepted_count++;
         end
         if (csr_valid && csr_ready) key_color = csr_wdata;

         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (idle_on && $urandom_range(0, 99) < rsp_stall_pct) begin
            stall_left <= $urandom_range(0, 16);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus
   function automatic void queue_cmd(logic command, int cx, int cy, int r,
                                     logic [cpg_pkg::COLOR_W-1:0] c);
      circle_cmd_type cmd;
      cmd.command  = command;
      cmd.center_x = cpg_pkg::CENTRE_W'(cx);
      cmd.center_y = cpg_pkg::CENTRE_W'(cy);
      cmd.radius   = 10'(r);
      cmd.color    = c;
      pending_cmds.push_back(cmd);
      queued_count++;
   endfunction

   function automatic void queue_advance();
      queue_cmd(cpg_pkg::CMD_ADVANCE, $urandom, $urandom, $urandom, $urandom);
   endfunction

   task automatic queue_random_circles(int n, logic [cpg_pkg::COLOR_W-1:0] key);
      int made;
      int r;
      int steps;
      logic [cpg_pkg::COLOR_W-1:0] c;
      made = 0;
      while (made < n) begin
         case ($urandom_range(0, 9))
            0: begin
               queue_cmd(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
               made++;
            end
            1: begin
               // skipped circle, then an advance that finds nothing live
               c = $urandom_range(0, 1) ? key : $urandom;
               r = (c == key) ? $urandom_range(0, 1023) : 0;
               queue_cmd(cpg_pkg::CMD_START, $urandom, $urandom, r, c);
               queue_advance();
               made += 2;
            end
            default: begin
               r = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 1023)
                                                : $urandom_range(1, 24);
               c = $urandom;
               if (c == key) c = ~key;
               steps = (r > 24) ? $urandom_range(0, 5) : r * 7 / 10 + $urandom_range(0, 2);
               if ($urandom_range(0, 5) == 0) steps = $urandom_range(0, steps);
               queue_cmd(cpg_pkg::CMD_START, $urandom, $urandom, r, c);
               repeat (steps) queue_advance();
               made += steps + 1;
            end
         endcase
      end
   endtask

   task automatic settle();
      do @(posedge clock);
      while (accepted_count != queued_count || expected_points.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key(logic [cpg_pkg::COLOR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      keys_written++;
   endtask

   initial begin
      logic [cpg_pkg::COLOR_W-1:0] key;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pass under the reset key of zero
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      queue_advance();
      queue_cmd(cpg_pkg::CMD_START, 5, 5, 0, 32'h0000_0005);
      queue_cmd(cpg_pkg::CMD_START, 5, 5, 5, 32'h0000_0000);
      queue_advance();
      queue_cmd(cpg_pkg::CMD_START, 0, 0, 1, 32'hA5A5_5A5A);
      queue_advance();
      queue_cmd(cpg_pkg::CMD_START, 1023, 1023, 2, 32'hFFFF_FFFF);
      queue_advance();
      queue_advance();
      queue_cmd(cpg_pkg::CMD_START, -1024, -1024, 1023, 32'h0000_0001);
      repeat (3) queue_advance();
      queue_cmd(cpg_pkg::CMD_START, -1024, 1023, 3, 32'h8000_0000);
      repeat (3) queue_advance();
      queue_cmd(cpg_pkg::CMD_START, 1023, -1024, 1023, 32'h7FFF_FFFF);
      queue_advance();
      queue_cmd(cpg_pkg::CMD_START, 0, 0, 0, 32'h1234_5678);
      queue_advance();
      settle();

      write_key(32'hFFFF_FFFF);
      queue_cmd(cpg_pkg::CMD_START, 0, 0, 7, 32'hFFFF_FFFF);
      queue_random_circles(90, 32'hFFFF_FFFF);
      settle();

      key = $urandom;
      write_key(key);
      req_gap_pct   = 40;
      rsp_stall_pct = 10;
      queue_random_circles(90, key);
      settle();

      idle_on = 1'b0;
      write_key(32'h0000_0000);
      queue_random_circles(70, 32'h0000_0000);
      settle();

      $display("Sent %0d commands (%0d starts, %0d advances) under %0d key settings;",
               accepted_count, starts_taken, advances_taken, keys_written + 1);
      $display("checked %0d points, %0d circles drawn to the end.",
               points_checked, circles_finished);
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/cpg_pkg.sv
sv/cpg_front.sv
sv/cpg_queue.sv
sv/cpg_back.sv
sv/circle_point_generator.sv
tb/sv/circle_point_generator_tb.sv
